@@ hdl/hdrtm_pkg.sv @@
// Shared types, constants and constant tables for the HDR tone mapping block.
// Used by hdrtm_lane, hdr_tone_mapping_pixel and the bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hdrtm_pkg;

	localparam int FRAC_BITS         = 16;
	localparam int LOG_TABLE_ENTRIES = 256;
	localparam int LOG_IDX_BITS      = $clog2(LOG_TABLE_ENTRIES);
	localparam int CW                = 24;   // channel width
	localparam int GW                = 16;   // inverse gamma width
	localparam int OPW               = 3;
	localparam int IDXW              = 3;    // register index width
	localparam int MANT_BITS         = 16;
	localparam int EXP_STEPS         = 16;
	localparam int EXP_FW            = 30;   // exp2 accumulator is Q1.30
	localparam int EVW               = EXP_FW + 1;

	localparam logic [CW-1:0] MAXV = '1;
	localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;

	// operator codes
	localparam logic [OPW-1:0] OP_CLAMP        = 3'd0;
	localparam logic [OPW-1:0] OP_LINEAR       = 3'd1;
	localparam logic [OPW-1:0] OP_LINEAR_CLAMP = 3'd2;
	localparam logic [OPW-1:0] OP_GAMMA        = 3'd3;
	localparam logic [OPW-1:0] OP_GAMMA_CLAMP  = 3'd4;
	localparam logic [OPW-1:0] OP_REINHARD     = 3'd5;
	localparam logic [OPW-1:0] OP_EXT_REINHARD = 3'd6;

	// register indexes
	localparam logic [IDXW-1:0] REG_TONE_OP   = 3'd0;
	localparam logic [IDXW-1:0] REG_CLAMP     = 3'd1;
	localparam logic [IDXW-1:0] REG_IMAGE_MAX = 3'd2;
	localparam logic [IDXW-1:0] REG_COLOR_RES = 3'd3;
	localparam logic [IDXW-1:0] REG_INV_GAMMA = 3'd4;

	// divider and datapath widths
	localparam int A_DW   = 2 * CW;                // c*R, or c << F
	localparam int T_W    = CW + FRAC_BITS;
	localparam int B_DW   = T_W + FRAC_BITS;       // t << F
	localparam int C_DW   = CW + FRAC_BITS;
	localparam int C_VW   = CW + 1;
	localparam int K_W    = CW + FRAC_BITS + 1;
	localparam int EXTP_W = FRAC_BITS + K_W;
	localparam logic [K_W-1:0] K_CAP = K_W'(1) << (CW + FRAC_BITS);

	// stage at which each path result sits in a register (stage 1 = input)
	localparam int ST_A     = 1 + A_DW;
	localparam int ST_B     = ST_A + B_DW;
	localparam int ST_K     = ST_B + 1;
	localparam int ST_P     = ST_K + 1;
	localparam int ST_C     = 1 + C_DW;
	localparam int ST_G     = 5 + EXP_STEPS + 1;
	localparam int LANE_LAT = ST_P;

	typedef struct packed {
		logic [CW-1:0] red_in;
		logic [CW-1:0] green_in;
		logic [CW-1:0] blue_in;
	} pixel_in_t;

	typedef struct packed {
		logic [CW-1:0] red_out;
		logic [CW-1:0] green_out;
		logic [CW-1:0] blue_out;
		logic          saturated;
	} pixel_out_t;

	typedef struct packed {
		logic [OPW-1:0] tone_op;
		logic [CW-1:0]  clamp_level;
		logic [CW-1:0]  image_max;
		logic [CW-1:0]  color_res;
		logic [GW-1:0]  inv_gamma;
	} cfg_t;

	typedef struct packed {
		logic [CW-1:0] value;
		logic          sat;
	} lane_res_t;

	localparam cfg_t CFG_RESET = '{
		tone_op:     OP_CLAMP,
		clamp_level: 24'd65536,
		image_max:   24'd65536,
		color_res:   24'd65536,
		inv_gamma:   16'd1862
	};

	typedef logic [MANT_BITS:0] log_tab_t [0:LOG_TABLE_ENTRIES];
	typedef logic [EVW-1:0]     exp_tab_t [0:EXP_STEPS-1];

	// log2 of 1 + i/N in Q.16 by repeated squaring
	function automatic log_tab_t build_log_tab();
		log_tab_t        t;
		longint unsigned y;
		logic [MANT_BITS:0] r;
		int              i;
		int              b;
		for (i = 0; i < LOG_TABLE_ENTRIES; i++) begin
			y = (64'd1 << 30) + ((longint'(i) << 30) / LOG_TABLE_ENTRIES);
			r = '0;
			for (b = MANT_BITS - 1; b >= 0; b--) begin
				y = (y * y) >> 30;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					r[b] = 1'b1;
				end
			end
			t[i] = r;
		end
		t[LOG_TABLE_ENTRIES] = (MANT_BITS + 1)'(1) << MANT_BITS;
		return t;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned n_in);
		longint unsigned n;
		longint unsigned r;
		longint unsigned bt;
		n  = n_in;
		r  = 0;
		bt = 64'd1 << 62;
		while (bt > n)
			bt = bt >> 2;
		while (bt != 0) begin
			if (n >= r + bt) begin
				n = n - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// factors 2^(2^-(k+1)) in Q1.30
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t        t;
		longint unsigned prev;
		int              k;
		prev = 64'd1 << 31;
		for (k = 0; k < EXP_STEPS; k++) begin
			prev = isqrt64(prev << 30);
			t[k] = prev[EVW-1:0];
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

@@ hdl/hdrtm_delay.sv @@
// Fixed-length register delay line used to align the lane paths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hdrtm_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dly_s [1:N];

	always_ff @(posedge clk) begin
		dly_s[1] <= d;
		for (int i = 2; i <= N; i++)
			dly_s[i] <= dly_s[i-1];
	end

	assign q = dly_s[N];

endmodule

`default_nettype wire

@@ hdl/hdrtm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, DW stages.
// No dependencies. A zero divisor gives a meaningless quotient.
`timescale 1ns / 1ps
`default_nettype none

module hdrtm_div #(
	parameter int DW = 8,
	parameter int VW = 8
) (
	input  logic          clk,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient
);

	logic [DW-1:0] num_s [1:DW];
	logic [VW-1:0] rem_s [1:DW];
	logic [VW-1:0] dv_s  [1:DW];

	for (genvar i = 0; i < DW; i++) begin : g_st
		logic [DW-1:0] num_i;
		logic [VW-1:0] rem_i;
		logic [VW-1:0] dv_i;
		logic [VW:0]   shifted;
		logic [VW:0]   trial;

		if (i == 0) begin : g_first
			assign num_i = dividend;
			assign rem_i = '0;
			assign dv_i  = divisor;
		end else begin : g_next
			assign num_i = num_s[i];
			assign rem_i = rem_s[i];
			assign dv_i  = dv_s[i];
		end

		assign shifted = {rem_i, num_i[DW-1]};
		assign trial   = shifted - {1'b0, dv_i};

		always_ff @(posedge clk) begin
			if (!trial[VW]) begin
				rem_s[i+1] <= trial[VW-1:0];
				num_s[i+1] <= {num_i[DW-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= shifted[VW-1:0];
				num_s[i+1] <= {num_i[DW-2:0], 1'b0};
			end
			dv_s[i+1] <= dv_i;
		end
	end

	assign quotient = num_s[DW];

endmodule

`default_nettype wire

@@ hdl/hdrtm_lane.sv @@
// One colour channel: clamp, linear, gamma and Reinhard paths side by side,
// aligned to a common stage. Depends on hdrtm_pkg, hdrtm_div, hdrtm_delay.
`timescale 1ns / 1ps
`default_nettype none

module hdrtm_lane (
	input  logic                     clk,
	input  hdrtm_pkg::cfg_t          cfg,
	input  logic [hdrtm_pkg::CW-1:0] chan,
	output hdrtm_pkg::lane_res_t     res
);

	import hdrtm_pkg::*;

	localparam int LRW   = $bits(lane_res_t);
	localparam int LGW   = 22;
	localparam int GPW   = LGW + GW + 1;
	localparam int EW    = GPW - 12;
	localparam int IPW   = EW - MANT_BITS;
	localparam int SHL_W = EVW + CW - 1;
	localparam int PW    = $clog2(CW);
	localparam logic [IPW:0] SH_OFF = (IPW + 1)'(EXP_FW - FRAC_BITS);

	// ---------------- stage 1
	logic [CW-1:0]   c_s1;
	logic [A_DW-1:0] prod_s1;

	always_ff @(posedge clk) begin
		c_s1    <= chan;
		prod_s1 <= A_DW'(chan) * A_DW'(cfg.color_res);
	end

	// ---------------- divider A: c*R/M for linear, t = (c << F)/L otherwise
	logic            is_lin;
	logic [A_DW-1:0] a_dividend;
	logic [CW-1:0]   a_divisor;
	logic [A_DW-1:0] qa;
	lane_res_t       lin_a;
	lane_res_t       lin_p;

	assign is_lin     = (cfg.tone_op == OP_LINEAR) || (cfg.tone_op == OP_LINEAR_CLAMP);
	assign a_dividend = is_lin ? prod_s1 : A_DW'({c_s1, {FRAC_BITS{1'b0}}});
	assign a_divisor  = is_lin ? cfg.image_max : cfg.clamp_level;

	hdrtm_div #(.DW(A_DW), .VW(CW)) u_div_a (
		.clk      (clk),
		.dividend (a_dividend),
		.divisor  (a_divisor),
		.quotient (qa)
	);

	always_comb begin
		lin_a.sat   = (cfg.image_max == '0) || (qa > A_DW'(MAXV));
		lin_a.value = lin_a.sat ? MAXV : qa[CW-1:0];
	end

	hdrtm_delay #(.W(LRW), .N(ST_P - ST_A)) u_dly_lin (
		.clk (clk),
		.d   (lin_a),
		.q   (lin_p)
	);

	// ---------------- divider B: (t << F)/L, then k = 1 + t/L capped
	logic [B_DW-1:0] qb;
	logic [B_DW:0]   ksum;
	logic [K_W-1:0]  k_sk;

	hdrtm_div #(.DW(B_DW), .VW(CW)) u_div_b (
		.clk      (clk),
		.dividend ({qa[T_W-1:0], {FRAC_BITS{1'b0}}}),
		.divisor  (cfg.clamp_level),
		.quotient (qb)
	);

	assign ksum = (B_DW + 1)'(qb) + (B_DW + 1)'(ONE);

	always_ff @(posedge clk)
		k_sk <= (ksum > (B_DW + 1)'(K_CAP)) ? K_CAP : ksum[K_W-1:0];

	// ---------------- divider C: Reinhard base (c << F)/(c + 1)
	logic [C_DW-1:0]      qc;
	logic [FRAC_BITS-1:0] base_k;
	logic [FRAC_BITS-1:0] base_sp;
	logic [EXTP_W-1:0]    extp_sp;

	hdrtm_div #(.DW(C_DW), .VW(C_VW)) u_div_c (
		.clk      (clk),
		.dividend ({c_s1, {FRAC_BITS{1'b0}}}),
		.divisor  (C_VW'(c_s1) + C_VW'(ONE)),
		.quotient (qc)
	);

	hdrtm_delay #(.W(FRAC_BITS), .N(ST_K - ST_C)) u_dly_base (
		.clk (clk),
		.d   (qc[FRAC_BITS-1:0]),
		.q   (base_k)
	);

	always_ff @(posedge clk) begin
		extp_sp <= EXTP_W'(base_k) * EXTP_W'(k_sk);
		base_sp <= base_k;
	end

	// ---------------- gamma: log2, scale by inverse gamma, exp2
	logic [PW-1:0]          msb;
	logic [CW-1:0]          norm;
	logic [PW-1:0]          gp_s2;
	logic [MANT_BITS-1:0]   gmf_s2;
	logic                   gz_s2;

	always_comb begin
		msb = '0;
		for (int i = 0; i < CW; i++)
			if (c_s1[i])
				msb = PW'(i);
		norm = c_s1 << (PW'(CW - 1) - msb);
	end

	always_ff @(posedge clk) begin
		gp_s2  <= msb;
		gmf_s2 <= norm[CW-2 -: MANT_BITS];
		gz_s2  <= (c_s1 == '0);
	end

	logic [LOG_IDX_BITS-1:0] gidx;
	logic [MANT_BITS-1:0]    grem;
	logic [MANT_BITS:0]      glo;
	logic [MANT_BITS:0]      ghi;
	logic [MANT_BITS:0]      glo_s3;
	logic [MANT_BITS:0]      gdiff_s3;
	logic [MANT_BITS-1:0]    grem_s3;
	logic [PW-1:0]           gp_s3;
	logic                    gz_s3;

	assign gidx = gmf_s2[MANT_BITS-1 -: LOG_IDX_BITS];
	assign grem = {gmf_s2[MANT_BITS-LOG_IDX_BITS-1:0], {LOG_IDX_BITS{1'b0}}};
	assign glo  = LOG_TAB[{1'b0, gidx}];
	assign ghi  = LOG_TAB[(LOG_IDX_BITS + 1)'(gidx) + 1'b1];

	always_ff @(posedge clk) begin
		glo_s3   <= glo;
		gdiff_s3 <= ghi - glo;
		grem_s3  <= grem;
		gp_s3    <= gp_s2;
		gz_s3    <= gz_s2;
	end

	logic [2*MANT_BITS:0] ginterp;
	logic [MANT_BITS:0]   glf_s4;
	logic [PW-1:0]        gp_s4;
	logic                 gz_s4;

	assign ginterp = (2 * MANT_BITS + 1)'(gdiff_s3) * (2 * MANT_BITS + 1)'(grem_s3);

	always_ff @(posedge clk) begin
		glf_s4 <= glo_s3 + ginterp[MANT_BITS +: MANT_BITS + 1];
		gp_s4  <= gp_s3;
		gz_s4  <= gz_s3;
	end

	logic signed [5:0]     gpm;
	logic signed [LGW-1:0] glg;
	logic signed [GPW-1:0] gprod;
	logic [EW-1:0]         ge_s5;
	logic                  gz_s5;

	always_comb begin
		gpm   = $signed({1'b0, gp_s4}) - 6'sd16;
		glg   = $signed({gpm, {MANT_BITS{1'b0}}} + {5'b0, glf_s4});
		gprod = glg * $signed({1'b0, cfg.inv_gamma});
	end

	// floor division by 4096 is an arithmetic shift
	always_ff @(posedge clk) begin
		ge_s5 <= gprod[GPW-1:12];
		gz_s5 <= gz_s4;
	end

	logic [EVW-1:0] gv_s [1:EXP_STEPS];
	logic [EW-1:0]  ge_s [1:EXP_STEPS];
	logic           gz_s [1:EXP_STEPS];

	for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
		logic [EVW-1:0]   v_i;
		logic [EW-1:0]    e_i;
		logic             z_i;
		logic [2*EVW-1:0] mul;

		if (j == 0) begin : g_first
			assign v_i = EVW'(1) << EXP_FW;
			assign e_i = ge_s5;
			assign z_i = gz_s5;
		end else begin : g_next
			assign v_i = gv_s[j];
			assign e_i = ge_s[j];
			assign z_i = gz_s[j];
		end

		assign mul = (2 * EVW)'(v_i) * (2 * EVW)'(EXP_TAB[j]);

		always_ff @(posedge clk) begin
			gv_s[j+1] <= e_i[MANT_BITS-1-j] ? mul[EXP_FW +: EVW] : v_i;
			ge_s[j+1] <= e_i;
			gz_s[j+1] <= z_i;
		end
	end

	logic [EVW-1:0]   gv;
	logic [IPW-1:0]   gip;
	logic [IPW:0]     gsh;
	logic [IPW:0]     gnsh;
	logic [SHL_W-1:0] gshl;
	logic [EVW-1:0]   gshr;
	lane_res_t        gam;
	lane_res_t        gam_g;
	lane_res_t        gam_p;

	always_comb begin
		gv    = gv_s[EXP_STEPS];
		gip   = ge_s[EXP_STEPS][EW-1:MANT_BITS];
		gsh   = {gip[IPW-1], gip} - SH_OFF;
		gnsh  = ~gsh + 1'b1;
		gshl  = SHL_W'(gv) << gsh[PW-1:0];
		gshr  = gv >> gnsh[PW-1:0];
		gam   = '0;
		if (cfg.inv_gamma == '0) begin
			gam.value = ONE;
		end else if (gz_s[EXP_STEPS]) begin
			gam = '0;
		end else if (!gsh[IPW]) begin
			if (gsh >= (IPW + 1)'(CW) || gshl > SHL_W'(MAXV)) begin
				gam.value = MAXV;
				gam.sat   = 1'b1;
			end else begin
				gam.value = gshl[CW-1:0];
			end
		end else if (gnsh < (IPW + 1)'(EVW)) begin
			if (gshr > EVW'(MAXV)) begin
				gam.value = MAXV;
				gam.sat   = 1'b1;
			end else begin
				gam.value = gshr[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk)
		gam_g <= gam;

	hdrtm_delay #(.W(LRW), .N(ST_P - ST_G)) u_dly_gam (
		.clk (clk),
		.d   (gam_g),
		.q   (gam_p)
	);

	// ---------------- raw channel for clamps and pass-through
	logic [CW-1:0] c_p;

	hdrtm_delay #(.W(CW), .N(ST_P - 1)) u_dly_c (
		.clk (clk),
		.d   (c_s1),
		.q   (c_p)
	);

	// ---------------- operator select
	logic over;
	logic ext_sat;

	assign over    = c_p > cfg.clamp_level;
	assign ext_sat = (cfg.clamp_level == '0) || (extp_sp[EXTP_W-1:CW+FRAC_BITS] != '0);

	always_comb begin
		res.value = c_p;
		res.sat   = 1'b0;
		case (cfg.tone_op)
			OP_CLAMP:        res.value = over ? cfg.clamp_level : c_p;
			OP_LINEAR:       res = lin_p;
			OP_LINEAR_CLAMP: if (over) res.value = cfg.clamp_level; else res = lin_p;
			OP_GAMMA:        res = gam_p;
			OP_GAMMA_CLAMP:  if (over) res.value = cfg.clamp_level; else res = gam_p;
			OP_REINHARD:     res.value = CW'(base_sp);
			OP_EXT_REINHARD: begin
				res.sat   = ext_sat;
				res.value = ext_sat ? MAXV : extp_sp[FRAC_BITS +: CW];
			end
			default:         res.value = c_p;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/hdr_tone_mapping_pixel.sv @@
// HDR tone mapping, one pixel per item, three channel lanes in parallel.
// The pipeline length is set by the two chained dividers of the
// extended Reinhard path. Throughput: one pixel every clock; busy stays low.
// Reset clears the configuration to defaults and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module hdr_tone_mapping_pixel (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  hdrtm_pkg::pixel_in_t       pixel,
	input  logic                       cfg_we,
	input  logic [hdrtm_pkg::IDXW-1:0] cfg_index,
	input  logic [hdrtm_pkg::CW-1:0]   cfg_data,
	output logic                       done,
	output hdrtm_pkg::pixel_out_t      result
);

	import hdrtm_pkg::*;

	localparam int OUT_LAT = LANE_LAT + 1;

	cfg_t             cfg_q;
	logic [ST_P:1]    vld_q;
	lane_res_t        res_r;
	lane_res_t        res_g;
	lane_res_t        res_b;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TONE_OP:   cfg_q.tone_op     <= cfg_data[OPW-1:0];
				REG_CLAMP:     cfg_q.clamp_level <= cfg_data;
				REG_IMAGE_MAX: cfg_q.image_max   <= cfg_data;
				REG_COLOR_RES: cfg_q.color_res   <= cfg_data;
				REG_INV_GAMMA: cfg_q.inv_gamma   <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	hdrtm_lane u_lane_r (.clk(clk), .cfg(cfg_q), .chan(pixel.red_in),   .res(res_r));
	hdrtm_lane u_lane_g (.clk(clk), .cfg(cfg_q), .chan(pixel.green_in), .res(res_g));
	hdrtm_lane u_lane_b (.clk(clk), .cfg(cfg_q), .chan(pixel.blue_in),  .res(res_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[ST_P-1:1], start & ~busy};
			done  <= vld_q[ST_P];
		end
	end

	// merge: the item is saturated if any lane was
	always_ff @(posedge clk) begin
		result.red_out   <= res_r.value;
		result.green_out <= res_g.value;
		result.blue_out  <= res_b.value;
		result.saturated <= res_r.sat | res_g.sat | res_b.sat;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(OUT_LAT) done)
		else $error("item accepted without a result after the pipeline latency");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, OUT_LAT))
		else $error("result strobe without a matching accepted item");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |-> (result.red_out == MAXV ||
			result.green_out == MAXV || result.blue_out == MAXV))
		else $error("saturation flagged but no channel at full scale");
`endif

endmodule

`default_nettype wire

@@ bench/hdr_tone_mapping_pixel_chk.sv @@
// Checker for hdr_tone_mapping_pixel: tracks register writes, predicts each pixel
// and compares every done strobe against the oldest prediction.
// Depends on hdrtm_pkg for the port types and codes.
`timescale 1ns / 1ps

module hdr_tone_mapping_pixel_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  hdrtm_pkg::pixel_in_t       pixel,
	input  logic                       cfg_we,
	input  logic [hdrtm_pkg::IDXW-1:0] cfg_index,
	input  logic [hdrtm_pkg::CW-1:0]   cfg_data,
	input  logic                       done,
	input  hdrtm_pkg::pixel_out_t      result,
	output int                         errors,
	output int                         pending
);
	import hdrtm_pkg::*;

	localparam longint unsigned TOP  = 64'hFFFFFF;
	localparam longint unsigned UNIT = 64'd1 << 16;

	logic [2:0]  op_r;
	logic [23:0] lvl_r, imax_r, res_r;
	logic [15:0] ig_r;

	longint unsigned log2_rom [0:256];
	longint unsigned pow2_rom [0:15];
	pixel_out_t      pixel_q [$];

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned acc, rt, bt;
		acc = n;
		rt  = 0;
		bt  = 64'd1 << 62;
		while (bt > acc)
			bt = bt >> 2;
		while (bt != 0) begin
			if (acc >= rt + bt) begin
				acc = acc - (rt + bt);
				rt  = (rt >> 1) + bt;
			end else begin
				rt = rt >> 1;
			end
			bt = bt >> 2;
		end
		return rt;
	endfunction

	initial begin
		longint unsigned y, cur;
		int i, b;
		for (i = 0; i < 256; i++) begin
			y = (64'd1 << 30) + ((longint'(i) << 30) / 256);
			log2_rom[i] = 0;
			for (b = 15; b >= 0; b--) begin
				y = (y * y) >> 30;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					log2_rom[i] = log2_rom[i] | (64'd1 << b);
				end
			end
		end
		log2_rom[256] = 65536;
		cur = 64'd1 << 31;
		for (i = 0; i < 16; i++) begin
			cur = int_sqrt(cur << 30);
			pow2_rom[i] = cur;
		end
	end

	// bit 24 carries the saturation flag
	function automatic logic [24:0] clip(input longint unsigned v);
		if (v > TOP)
			return {1'b1, 24'hFFFFFF};
		return {1'b0, v[23:0]};
	endfunction

	function automatic longint fdiv(input longint a, input longint d);
		return a >= 0 ? a / d : -((-a + d - 1) / d);
	endfunction

	function automatic logic [24:0] gamma_ch(input longint unsigned c);
		int p, sh, b;
		longint unsigned mf, prod, ix, rem, lf, v;
		longint lg, e, ip, f;
		if (ig_r == 0)
			return clip(UNIT);
		if (c == 0)
			return '0;
		p = 23;
		while (((c >> p) & 1) == 0)
			p--;
		if (p >= 16)
			mf = (c >> (p - 16)) & 16'hFFFF;
		else
			mf = (c << (16 - p)) & 16'hFFFF;
		prod = mf * 256;
		ix   = prod >> 16;
		rem  = prod & 16'hFFFF;
		lf   = log2_rom[ix] + (((log2_rom[ix+1] - log2_rom[ix]) * rem) >> 16);
		lg   = longint'(p - 16) * 65536 + longint'(lf);
		e    = fdiv(lg * longint'(ig_r), 4096);
		ip   = fdiv(e, 65536);
		f    = e - ip * 65536;
		v    = 64'd1 << 30;
		for (b = 15; b >= 0; b--)
			if ((f >> b) & 1)
				v = (v * pow2_rom[15-b]) >> 30;
		sh = int'(ip) + 16 - 30;
		if (sh >= 0) begin
			if (sh >= 24)
				return clip(TOP + 1);
			return clip(v << sh);
		end
		if (-sh >= 63)
			return '0;
		return clip(v >> (-sh));
	endfunction

	function automatic logic [24:0] linear_ch(input longint unsigned c);
		if (imax_r == 0)
			return clip(TOP + 1);
		return clip((c * res_r) / imax_r);
	endfunction

	function automatic logic [24:0] ext_reinhard_ch(input longint unsigned c);
		longint unsigned wl, t, q, r, k, base, lim, cap;
		cap = 64'd1 << 40;
		wl  = lvl_r;
		if (wl == 0)
			return clip(TOP + 1);
		t = (c << 16) / wl;
		q = t / wl;
		r = t % wl;
		if (q >= (64'd1 << 25)) begin
			k = cap;
		end else begin
			k = UNIT + (q << 16) + ((r << 16) / wl);
			if (k > cap)
				k = cap;
		end
		base = (c << 16) / (c + UNIT);
		if (base == 0)
			return '0;
		lim = (cap + base - 1) / base;
		if (k >= lim)
			return clip(TOP + 1);
		return clip((base * k) >> 16);
	endfunction

	function automatic logic [24:0] tone_ch(input logic [23:0] c);
		longint unsigned cv;
		cv = c;
		case (op_r)
			OP_CLAMP:        return {1'b0, (c > lvl_r) ? lvl_r : c};
			OP_LINEAR:       return linear_ch(cv);
			OP_LINEAR_CLAMP: return (c > lvl_r) ? {1'b0, lvl_r} : linear_ch(cv);
			OP_GAMMA:        return gamma_ch(cv);
			OP_GAMMA_CLAMP:  return (c > lvl_r) ? {1'b0, lvl_r} : gamma_ch(cv);
			OP_REINHARD:     return clip((cv << 16) / (cv + UNIT));
			OP_EXT_REINHARD: return ext_reinhard_ch(cv);
			default:         return {1'b0, c};
		endcase
	endfunction

	function automatic pixel_out_t tone_pixel(input pixel_in_t px);
		pixel_out_t  o;
		logic [24:0] r, g, b;
		r = tone_ch(px.red_in);
		g = tone_ch(px.green_in);
		b = tone_ch(px.blue_in);
		o.red_out   = r[23:0];
		o.green_out = g[23:0];
		o.blue_out  = b[23:0];
		o.saturated = r[24] | g[24] | b[24];
		return o;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		pixel_out_t want;
		if (!arst_n) begin
			op_r   <= CFG_RESET.tone_op;
			lvl_r  <= CFG_RESET.clamp_level;
			imax_r <= CFG_RESET.image_max;
			res_r  <= CFG_RESET.color_res;
			ig_r   <= CFG_RESET.inv_gamma;
			pixel_q.delete();
			pending = 0;
		end else begin
			if (start && !busy)
				pixel_q.push_back(tone_pixel(pixel));
			if (done) begin
				if (pixel_q.size() == 0) begin
					report("unexpected pixel", longint'(result.red_out), 0);
				end else begin
					want = pixel_q.pop_front();
					if (result.red_out !== want.red_out)
						report("red", result.red_out, want.red_out);
					if (result.green_out !== want.green_out)
						report("green", result.green_out, want.green_out);
					if (result.blue_out !== want.blue_out)
						report("blue", result.blue_out, want.blue_out);
					if (result.saturated !== want.saturated)
						report("saturated", result.saturated, want.saturated);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TONE_OP:   op_r   <= cfg_data[2:0];
					REG_CLAMP:     lvl_r  <= cfg_data;
					REG_IMAGE_MAX: imax_r <= cfg_data;
					REG_COLOR_RES: res_r  <= cfg_data;
					REG_INV_GAMMA: ig_r   <= cfg_data[15:0];
					default: ;
				endcase
			end
			pending = pixel_q.size();
		end
	end

endmodule

@@ bench/hdr_tone_mapping_pixel_tb.sv @@
// Top of the hdr_tone_mapping_pixel bench: clock, reset, register phases and pixel stimulus.
// Depends on hdrtm_pkg, the block and hdr_tone_mapping_pixel_chk.
`timescale 1ns / 1ps

module hdr_tone_mapping_pixel_tb;
	import hdrtm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN       = 130;    // longer than the pipeline

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	pixel_in_t   pixel;
	logic        cfg_we;
	logic [IDXW-1:0] cfg_index;
	logic [CW-1:0]   cfg_data;
	logic        done;
	pixel_out_t  result;
	int          errors;
	int          pending;
	int          cycles;
	bit          idle_en;
	int          sent;

	hdr_tone_mapping_pixel DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	hdr_tone_mapping_pixel_chk chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result(result), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [CW-1:0] pick_level();
		case ($urandom_range(7))
			0: return 24'd0;
			1: return 24'd1;
			2: return 24'hFFFFFF;
			3: return 24'(ONE);
			4: return 24'($urandom_range(1, 4 * 65536));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [CW-1:0] pick_chan();
		case ($urandom_range(9))
			0: return 24'd0;
			1: return 24'd1;
			2: return 24'hFFFFFF;
			3: return 24'(ONE);
			4: return 24'($urandom_range(0, 255));
			5, 6: return 24'($urandom_range(0, 4 * 65536));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// only while the pipeline is empty
	task automatic set_regs(input logic [OPW-1:0] op, input logic [CW-1:0] lvl,
			input logic [CW-1:0] imax, input logic [CW-1:0] res, input logic [GW-1:0] ig);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		write_reg(REG_TONE_OP, CW'(op));
		write_reg(REG_CLAMP, lvl);
		write_reg(REG_IMAGE_MAX, imax);
		write_reg(REG_COLOR_RES, res);
		write_reg(REG_INV_GAMMA, CW'(ig));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
			input logic [CW-1:0] b);
		bit hold;
		if (idle_en && $urandom_range(99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= '{red_in: r, green_in: g, blue_in: b};
		do begin
			@(negedge clk);
			hold = busy;
			@(posedge clk);
		end while (hold);
		sent++;
	endtask

	initial begin
		logic [OPW-1:0] op;
		int i, n;
		arst_n    = 1'b0;
		start     = 1'b0;
		pixel     = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		idle_en   = 1'b1;
		sent      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: three pixels per operator, unused code included
		for (i = 0; i < 8; i++) begin
			op = OPW'(i);
			case (i)
				1: set_regs(op, 24'h010000, 24'd0, 24'hFFFFFF, 16'd1862);
				3: set_regs(op, 24'h010000, 24'h010000, 24'h010000, 16'd0);
				4: set_regs(op, 24'd1, 24'h010000, 24'h010000, 16'hFFFF);
				6: set_regs(op, 24'd0, 24'h010000, 24'h010000, 16'd1);
				default: set_regs(op, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 16'd1862);
			endcase
			send_pixel(24'd0, 24'd1, 24'hFFFFFF);
			send_pixel(24'(ONE), 24'h000100, 24'h7FFFFF);
			send_pixel(24'h800000, 24'hAAAAAA, 24'h555555);
		end

		// random phases; one with no idling at all
		n = 0;
		while (sent < 900) begin
			idle_en = (n != 3);
			set_regs(OPW'($urandom_range(7)), pick_level(), pick_level(), pick_level(),
				($urandom_range(3) == 0) ? GW'($urandom) : GW'($urandom_range(0, 8192)));
			for (i = 0; i < 60; i++)
				send_pixel(pick_chan(), pick_chan(), pick_chan());
			n++;
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
